FILE: sv/rrb_pkg.sv
// Shared types and constants for the reorder receive buffer.
// No dependencies.
`default_nettype none
package rrb_pkg;
	localparam int HDR_LEN = 12;
	localparam int SUM_START = 16;

	typedef enum logic [2:0] {
		ST_ACKED = 3'd0,
		ST_BAD_SUM = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_PAYLOAD = 3'd4,
		ST_NOTHING = 3'd5,
		ST_HALTED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_NOT_FOUND = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_PULL_WAIT,
		FSM_EVAL
	} fsm_t;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_PULL = 1'b1;
endpackage
`default_nettype wire

FILE: sv/rrb_mem.sv
// Payload memory: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module rrb_mem #(
	parameter int DEPTH = 9216,
	parameter int AW = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: sv/reorder_receive_buffer.sv
// Reorder receive buffer top level: datagram parser, slot table, release logic.
// Depends on rrb_pkg and rrb_mem.
//
// Channel   Dir  Handshake           Fields
// request   in   in_valid/in_stall   func, data_byte, datagram_end
// result    out  out_valid/out_stall status, ack_index, released, out_byte,
//                                    payload_last, transfer_done
//
// A final datagram byte moves to an evaluation state (verdict, slot insertion and release)
// except while halted. A pull of a pending byte passes through a wait state for the
// registered memory read; a pull with nothing pending gives its result directly.
// Reset clears the slot table, datagram state and error flag at once; the payload
// memory is never cleared and needs no clearing pass.
// A held result stalls new requests only while it is itself stalled.
//
// Payload bytes are written straight into a spare memory region while a datagram
// arrives. Each slot maps to one of SLOTS+1 regions; when a packet is stored, the
// chosen slot takes the spare region and its old region becomes the new spare,
// so no copy is needed.
`default_nettype none
module reorder_receive_buffer #(
	parameter int SLOTS = 8,
	parameter int DATAGRAM_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  data_byte,
	input  wire logic        datagram_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [2:0]  status,
	output logic      [31:0] ack_index,
	output logic             released,
	output logic      [7:0]  out_byte,
	output logic             payload_last,
	output logic             transfer_done
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = $clog2(SLOTS + 1);
	localparam int CW = $clog2(DATAGRAM_BYTES + 1);
	localparam int OW = $clog2(DATAGRAM_BYTES);
	localparam int DEPTH = (SLOTS + 1) * DATAGRAM_BYTES;
	localparam int AW = $clog2(DEPTH);

	// Slot table.
	logic [SLOTS-1:0] slot_valid_q, slot_valid_d;
	logic [31:0]      slot_index_q [SLOTS];
	logic [CW-1:0]    slot_len_q [SLOTS];
	logic [RW-1:0]    slot_map_q [SLOTS];
	logic [RW-1:0]    spare_q, spare_d;

	// Datagram in flight.
	logic [CW-1:0] count_q, count_d;
	logic [31:0]   hsum_q, hsum_d, htot_q, htot_d, hidx_q, hidx_d, rsum_q, rsum_d;
	logic [7:0]    sh_q [rrb_pkg::HDR_LEN];
	logic          shift_en;

	logic [31:0]   next_q, next_d, latest_q, latest_d;
	logic          pend_q, pend_d;
	logic [SW-1:0] pull_slot_q, pull_slot_d;
	logic [RW-1:0] pull_reg_q, pull_reg_d;
	logic [CW-1:0] pull_len_q, pull_len_d;
	logic [OW-1:0] pull_off_q, pull_off_d;
	logic [1:0]    err_q, err_d;

	rrb_pkg::fsm_t state_q, state_d;

	// Output register.
	logic        ov_q, ov_d;
	logic [2:0]  st_q, st_d;
	logic [31:0] ack_q, ack_d;
	logic        rel_q, rel_d, last_q, last_d, done_q, done_d, byte_sel_q, byte_sel_d;

	// Memory ports.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata;

	// Table updates chosen in the evaluation cycle.
	logic          ins_en, rel_en;
	logic [SW-1:0] ins_slot, rel_slot;
	logic          accept;

	rrb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (data_byte),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_stall = (state_q != rrb_pkg::FSM_IDLE) || (ov_q && out_stall);
	assign accept = in_valid && !in_stall;

	assign out_valid = ov_q;
	assign status = st_q;
	assign ack_index = ack_q;
	assign released = rel_q;
	assign out_byte = byte_sel_q ? mem_rdata : 8'd0;
	assign payload_last = last_q;
	assign transfer_done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrb_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic [CW-1:0]    k;
		logic [CW-1:0]    plen;
		logic [SLOTS-1:0] free_v, match_v;
		logic             found_free, found_rel, ins_match;
		logic [CW-1:0]    rlen;
		logic [RW-1:0]    rreg;
		state_d = state_q;
		count_d = count_q;
		hsum_d = hsum_q;
		htot_d = htot_q;
		hidx_d = hidx_q;
		rsum_d = rsum_q;
		next_d = next_q;
		latest_d = latest_q;
		pend_d = pend_q;
		pull_slot_d = pull_slot_q;
		pull_reg_d = pull_reg_q;
		pull_len_d = pull_len_q;
		pull_off_d = pull_off_q;
		err_d = err_q;
		slot_valid_d = slot_valid_q;
		spare_d = spare_q;
		ov_d = ov_q && out_stall;
		st_d = st_q;
		ack_d = ack_q;
		rel_d = rel_q;
		last_d = last_q;
		done_d = done_q;
		byte_sel_d = byte_sel_q;
		shift_en = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = '0;
		mem_raddr = AW'(pull_reg_q) * AW'(DATAGRAM_BYTES) + AW'(pull_off_q);
		ins_en = 1'b0;
		rel_en = 1'b0;
		ins_slot = '0;
		rel_slot = '0;
		k = count_q;
		plen = (count_q > CW'(rrb_pkg::HDR_LEN)) ? count_q - CW'(rrb_pkg::HDR_LEN) : '0;
		found_free = 1'b0;
		found_rel = 1'b0;
		rlen = '0;
		rreg = '0;
		free_v = ~slot_valid_q;
		match_v = '0;
		ins_match = 1'b0;

		unique case (state_q)
			rrb_pkg::FSM_IDLE: begin
				if (accept && func == rrb_pkg::FUNC_PULL) begin
					ov_d = 1'b1;
					ack_d = '0;
					rel_d = 1'b0;
					done_d = $signed(next_q) >= $signed(latest_q);
					if (!pend_q) begin
						st_d = rrb_pkg::ST_NOTHING;
						last_d = 1'b0;
						byte_sel_d = 1'b0;
					end else begin
						st_d = rrb_pkg::ST_PAYLOAD;
						byte_sel_d = 1'b1;
						mem_re = 1'b1;
						ov_d = 1'b0;
						state_d = rrb_pkg::FSM_PULL_WAIT;
						if (CW'(pull_off_q) + CW'(1) >= pull_len_q) begin
							last_d = 1'b1;
							slot_valid_d[pull_slot_q] = 1'b0;
							pend_d = 1'b0;
							pull_off_d = '0;
						end else begin
							last_d = 1'b0;
							pull_off_d = pull_off_q + OW'(1);
						end
					end
				end else if (accept && err_q != rrb_pkg::ERR_NONE) begin
					if (datagram_end) begin
						count_d = '0;
						hsum_d = '0;
						htot_d = '0;
						hidx_d = '0;
						rsum_d = '0;
						ov_d = 1'b1;
						st_d = rrb_pkg::ST_HALTED;
						ack_d = '0;
						rel_d = 1'b0;
						last_d = 1'b0;
						byte_sel_d = 1'b0;
						done_d = $signed(next_q) >= $signed(latest_q);
					end
				end else if (accept) begin
					if (k < CW'(DATAGRAM_BYTES)) begin
						shift_en = 1'b1;
						if (k < CW'(4)) begin
							hsum_d = {hsum_q[23:0], data_byte};
						end else if (k < CW'(8)) begin
							htot_d = {htot_q[23:0], data_byte};
						end else if (k < CW'(rrb_pkg::HDR_LEN)) begin
							hidx_d = {hidx_q[23:0], data_byte};
						end
						if (k >= CW'(rrb_pkg::SUM_START)) begin
							rsum_d = rsum_q + {{24{sh_q[rrb_pkg::HDR_LEN-1][7]}},
								sh_q[rrb_pkg::HDR_LEN-1]};
						end
						if (k >= CW'(rrb_pkg::HDR_LEN)) begin
							mem_we = 1'b1;
							mem_waddr = AW'(spare_q) * AW'(DATAGRAM_BYTES)
								+ AW'(k - CW'(rrb_pkg::HDR_LEN));
						end
						count_d = k + CW'(1);
					end
					if (datagram_end) begin
						state_d = rrb_pkg::FSM_EVAL;
					end
				end
			end
			rrb_pkg::FSM_PULL_WAIT: begin
				ov_d = 1'b1;
				state_d = rrb_pkg::FSM_IDLE;
			end
			rrb_pkg::FSM_EVAL: begin
				state_d = rrb_pkg::FSM_IDLE;
				ov_d = 1'b1;
				ack_d = '0;
				last_d = 1'b0;
				byte_sel_d = 1'b0;
				latest_d = htot_q;
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (free_v[i]) begin
						found_free = 1'b1;
						ins_slot = SW'(i);
					end
				end
				for (int i = 0; i < SLOTS; i++) begin
					match_v[i] = slot_valid_q[i] && (slot_index_q[i] == next_q);
				end
				ins_match = hidx_q == next_q;
				if (htot_q == '0 && hidx_q == '0) begin
					err_d = rrb_pkg::ERR_NOT_FOUND;
					st_d = rrb_pkg::ST_NOT_FOUND;
				end else if (hsum_q != rsum_q) begin
					st_d = rrb_pkg::ST_BAD_SUM;
					rel_en = !pend_q;
				end else if (!found_free) begin
					err_d = rrb_pkg::ERR_OVERFLOW;
					st_d = rrb_pkg::ST_OVERFLOW;
				end else begin
					ins_en = 1'b1;
					st_d = rrb_pkg::ST_ACKED;
					ack_d = hidx_q;
					slot_valid_d[ins_slot] = 1'b1;
					spare_d = slot_map_q[ins_slot];
					if (ins_match) begin
						match_v[ins_slot] = 1'b1;
					end
					rel_en = !pend_q;
				end
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (match_v[i]) begin
						found_rel = 1'b1;
						rel_slot = SW'(i);
					end
				end
				rel_en = rel_en && found_rel;
				rel_d = rel_en;
				if (rel_en) begin
					if (ins_en && rel_slot == ins_slot) begin
						rlen = plen;
						rreg = spare_q;
					end else begin
						rlen = slot_len_q[rel_slot];
						rreg = slot_map_q[rel_slot];
					end
					next_d = next_q + 32'd1;
					if (rlen == '0) begin
						slot_valid_d[rel_slot] = 1'b0;
					end else begin
						pend_d = 1'b1;
						pull_slot_d = rel_slot;
						pull_reg_d = rreg;
						pull_len_d = rlen;
						pull_off_d = '0;
					end
				end
				done_d = $signed(next_d) >= $signed(htot_q);
				count_d = '0;
				hsum_d = '0;
				htot_d = '0;
				hidx_d = '0;
				rsum_d = '0;
			end
			default: begin
				state_d = rrb_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			spare_q <= RW'(SLOTS);
			count_q <= '0;
			hsum_q <= '0;
			htot_q <= '0;
			hidx_q <= '0;
			rsum_q <= '0;
			next_q <= '0;
			latest_q <= '0;
			pend_q <= 1'b0;
			pull_slot_q <= '0;
			pull_off_q <= '0;
			err_q <= rrb_pkg::ERR_NONE;
			ov_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_map_q[i] <= RW'(i);
			end
		end else begin
			slot_valid_q <= slot_valid_d;
			spare_q <= spare_d;
			count_q <= count_d;
			hsum_q <= hsum_d;
			htot_q <= htot_d;
			hidx_q <= hidx_d;
			rsum_q <= rsum_d;
			next_q <= next_d;
			latest_q <= latest_d;
			pend_q <= pend_d;
			pull_slot_q <= pull_slot_d;
			pull_off_q <= pull_off_d;
			err_q <= err_d;
			ov_q <= ov_d;
			if (ins_en) begin
				slot_map_q[ins_slot] <= spare_q;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		pull_reg_q <= pull_reg_d;
		pull_len_q <= pull_len_d;
		st_q <= st_d;
		ack_q <= ack_d;
		rel_q <= rel_d;
		last_q <= last_d;
		done_q <= done_d;
		byte_sel_q <= byte_sel_d;
		if (ins_en) begin
			slot_index_q[ins_slot] <= hidx_q;
			slot_len_q[ins_slot] <= (count_q > CW'(rrb_pkg::HDR_LEN))
				? count_q - CW'(rrb_pkg::HDR_LEN) : '0;
		end
		if (shift_en) begin
			sh_q[0] <= data_byte;
			for (int i = 1; i < rrb_pkg::HDR_LEN; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	// A slot being pulled stays occupied until its last byte goes out.
	a_pend_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> slot_valid_q[pull_slot_q])
		else $error("pending pull slot not valid");

	// Errors never clear once raised.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != rrb_pkg::ERR_NONE |=> err_q == $past(err_q))
		else $error("error state changed");

	// The spare region is never the region of the slot being pulled.
	a_spare_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> spare_q != pull_reg_q)
		else $error("spare region in use by pull");

	// The wait state of a pull with a pending payload is followed by a payload result.
	a_pull_latency: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrb_pkg::FSM_PULL_WAIT |=> out_valid
		&& status == rrb_pkg::ST_PAYLOAD)
		else $error("pull result missing");
endmodule
`default_nettype wire
